### rtl/bwc_pkg.sv
// Package for the block word checksum: widths, seed constant, tail mixing tables.
// No dependencies; used by every module in rtl/.
package bwc_pkg;

    localparam int COUNT_BITS = 20;
    localparam int WORD_BITS  = 32;
    localparam int REP_BITS   = 3;   // leftover words per block: 0..7

    localparam logic [WORD_BITS-1:0]  SEED_MULT = 32'h3487_9945;
    localparam logic [COUNT_BITS-1:0] WC_RESET  = COUNT_BITS'(31);
    localparam logic [WORD_BITS-1:0]  SEED_RESET =
        WORD_BITS'(64'(WC_RESET) * 64'(SEED_MULT));

    // one block's closing job: z*33^r + t*(33^(r-1)+...+1)
    typedef struct packed {
        logic [WORD_BITS-1:0] z;
        logic [WORD_BITS-1:0] t;
        logic [REP_BITS-1:0]  r;
    } t_tail_req;

    // 33^r mod 2^32
    function automatic logic [WORD_BITS-1:0] pow33(input logic [REP_BITS-1:0] r);
        logic [WORD_BITS-1:0] v;
        case (r)
            3'd0:    v = 32'd1;
            3'd1:    v = 32'd33;
            3'd2:    v = 32'd1089;
            3'd3:    v = 32'd35937;
            3'd4:    v = 32'd1185921;
            3'd5:    v = 32'd39135393;
            3'd6:    v = 32'd1291467969;
            3'd7:    v = 32'd3963737313;
            default: v = 32'd1;
        endcase
        return v;
    endfunction

    // sum of 33^k for k < r, mod 2^32
    function automatic logic [WORD_BITS-1:0] geo33(input logic [REP_BITS-1:0] r);
        logic [WORD_BITS-1:0] v;
        case (r)
            3'd0:    v = 32'd0;
            3'd1:    v = 32'd1;
            3'd2:    v = 32'd34;
            3'd3:    v = 32'd1123;
            3'd4:    v = 32'd37060;
            3'd5:    v = 32'd1222981;
            3'd6:    v = 32'd40358374;
            3'd7:    v = 32'd1331826343;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // bytes b0..b3 (b0 on top) ORed at shifts 23, 16, 7, 0
    function automatic logic [WORD_BITS-1:0] remix(input logic [WORD_BITS-1:0] w);
        return ({24'd0, w[31:24]} << 23) | ({24'd0, w[23:16]} << 16) |
               ({24'd0, w[15:8]} << 7)   |  {24'd0, w[7:0]};
    endfunction

endpackage

### rtl/bwc_hash.sv
// Running hash and word counter: mixes one word per beat, hands closing jobs downstream.
// Depends on bwc_pkg.
module bwc_hash (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bwc_pkg::COUNT_BITS-1:0]  i_cfg_data,
    input  logic                            i_beat,
    input  logic [bwc_pkg::WORD_BITS-1:0]   i_word,
    output logic                            o_ready,
    output logic                            o_req_valid,
    output bwc_pkg::t_tail_req              o_req,
    input  logic                            i_req_ready
);
    import bwc_pkg::*;

    logic [COUNT_BITS-1:0] r_wc, n_wc;
    logic [WORD_BITS-1:0]  r_seed, n_seed;
    logic [COUNT_BITS-1:0] r_seen, n_seen;
    logic [WORD_BITS-1:0]  r_hash, n_hash;
    logic [WORD_BITS-1:0]  r_tail_t, n_tail_t;
    logic                  r_req_valid, n_req_valid;
    t_tail_req             r_req, n_req;

    logic [WORD_BITS-1:0]  base, mix, t_now;
    logic [COUNT_BITS-1:0] full;
    logic [COUNT_BITS:0]   seen_inc;
    logic                  last, in_full, at_tail, wc_zero;

    assign o_ready     = !r_req_valid || i_req_ready;
    assign o_req_valid = r_req_valid;
    assign o_req       = r_req;

    always_comb begin
        base     = (r_seen == '0) ? r_seed : r_hash;
        mix      = base + ((base << 5) ^ i_word);
        t_now    = remix(i_word);
        full     = {r_wc[COUNT_BITS-1:REP_BITS], {REP_BITS{1'b0}}};
        seen_inc = {1'b0, r_seen} + (COUNT_BITS+1)'(1);
        wc_zero  = (r_wc == '0);
        last     = seen_inc >= {1'b0, r_wc};
        in_full  = r_seen < full;
        at_tail  = r_seen == full;
    end

    always_comb begin
        n_wc        = r_wc;
        n_seed      = r_seed;
        n_seen      = r_seen;
        n_hash      = r_hash;
        n_tail_t    = r_tail_t;
        n_req_valid = r_req_valid && !i_req_ready;
        n_req       = r_req;
        if (i_cfg_we) begin
            n_wc   = i_cfg_data;
            n_seed = WORD_BITS'(64'(i_cfg_data) * 64'(SEED_MULT));
            n_seen = '0;
            n_hash = '0;
        end else if (i_beat) begin
            if (at_tail) begin
                n_tail_t = t_now;
            end
            if (wc_zero || last) begin
                n_seen      = '0;
                n_hash      = '0;
                n_req_valid = 1'b1;
                if (wc_zero) begin
                    n_req = '{z: '0, t: '0, r: '0};
                end else if (r_wc[REP_BITS-1:0] == '0) begin
                    n_req = '{z: mix, t: '0, r: '0};
                end else begin
                    // hash is frozen once the tail word has been seen
                    n_req = '{z: base, t: (at_tail ? t_now : r_tail_t),
                              r: r_wc[REP_BITS-1:0]};
                end
            end else begin
                n_seen = seen_inc[COUNT_BITS-1:0];
                n_hash = in_full ? mix : base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc        <= WC_RESET;
            r_seed      <= SEED_RESET;
            r_seen      <= '0;
            r_hash      <= '0;
            r_req_valid <= 1'b0;
        end else begin
            r_wc        <= n_wc;
            r_seed      <= n_seed;
            r_seen      <= n_seen;
            r_hash      <= n_hash;
            r_req_valid <= n_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail_t <= n_tail_t;
        r_req    <= n_req;
    end

    a_seen_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wc != '0) |-> (r_seen < r_wc))
        else $error("word counter ran past block length");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_seen == '0))
        else $error("config write did not restart the block");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && !i_cfg_we && (last || wc_zero)) |=> r_req_valid)
        else $error("block end produced no closing job");

endmodule

### rtl/bwc_tail.sv
// Closing stage: folds the leftover-word repeats in with two table multiplies,
// then holds the checksum in the output register. Depends on bwc_pkg.
module bwc_tail (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  bwc_pkg::t_tail_req             i_req,
    output logic                           o_req_ready,
    output logic                           o_valid,
    output logic [bwc_pkg::WORD_BITS-1:0]  o_data,
    input  logic                           i_ready
);
    import bwc_pkg::*;

    logic                 r_prod_valid, n_prod_valid;
    logic [WORD_BITS-1:0] r_prod_z, n_prod_z;
    logic [WORD_BITS-1:0] r_prod_t, n_prod_t;
    logic                 r_out_valid, n_out_valid;
    logic [WORD_BITS-1:0] r_out, n_out;
    logic                 out_free, prod_free;

    assign out_free    = !r_out_valid || i_ready;
    assign prod_free   = !r_prod_valid || out_free;
    assign o_req_ready = prod_free;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    always_comb begin
        n_prod_valid = r_prod_valid;
        n_prod_z     = r_prod_z;
        n_prod_t     = r_prod_t;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        if (out_free) begin
            n_out_valid = r_prod_valid;
            n_out       = r_prod_z + r_prod_t;
        end
        if (prod_free) begin
            n_prod_valid = i_req_valid;
            n_prod_z     = WORD_BITS'(i_req.z * pow33(i_req.r));
            n_prod_t     = WORD_BITS'(i_req.t * geo33(i_req.r));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prod_valid <= n_prod_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_z <= n_prod_z;
        r_prod_t <= n_prod_t;
        r_out    <= n_out;
    end

    a_prod_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod_valid && out_free) |=> r_out_valid)
        else $error("product stage lost a job");

    a_prod_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod_valid && !out_free) |=> (r_prod_valid && $stable(r_prod_z)))
        else $error("product stage overwritten while stalled");

    a_req_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && prod_free) |=> r_prod_valid)
        else $error("closing job dropped");

endmodule

### rtl/block_word_checksum.sv
// Top level of the block word checksum: hash/counter stage plus closing stage.
// Depends on bwc_pkg, bwc_hash, bwc_tail.
//
//  channel   | dir | tdata                      | notes
//  s_axis    | in  | [31:0] data_word           | one storage word per beat
//  m_axis    | out | [31:0] checksum            | one beat per finished block
//  cfg       | in  | i_cfg_data[19:0] word_count| write strobe i_cfg_we
//
// One word per cycle sustained while s_axis_tready stays high; the running hash updates in the accept cycle.
// After the edge that takes the block's last beat, a checksum passes through the job reg,
// the product registers and the output register, in that order.
// Reset (synchronous, active low) sets word_count to 31 and empties the pipeline.
// Input stalls only while the closing stages are full and m_axis_tready is low.
module block_word_checksum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bwc_pkg::COUNT_BITS-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,   // [31:0] data_word
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata    // [31:0] checksum
);
    import bwc_pkg::*;

    logic      beat;
    logic      req_valid, req_ready;
    t_tail_req req;

    assign beat = s_axis_tvalid && s_axis_tready;

    bwc_hash u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_beat      (beat),
        .i_word      (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    bwc_tail u_tail (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_valid     (m_axis_tvalid),
        .o_data      (m_axis_tdata),
        .i_ready     (m_axis_tready)
    );

endmodule

### test/block_word_checksum_test.sv
// Self-checking bench for block_word_checksum: random word streams, stalls, count changes.
// Depends on bwc_pkg and the block_word_checksum RTL; a scoreboard class tracks the hash.
`timescale 1ns / 100ps

module block_word_checksum_test;

    import bwc_pkg::*;

    localparam int WAIT_CYCLES = 8;      // covers the closing pipeline
    localparam int RANDOM_WORDS = 800;

    class block_hash_tracker;
        logic [COUNT_BITS-1:0] words_per_block;
        logic [COUNT_BITS-1:0] seen;
        logic [31:0]           hash_acc;
        logic [31:0]           pending_sums[$];
        int                    errors;

        function new();
            words_per_block = WC_RESET;
            seen            = '0;
            hash_acc        = '0;
            errors          = 0;
        endfunction

        // a count write drops the block in progress
        function void set_count(logic [COUNT_BITS-1:0] v);
            words_per_block = v;
            seen            = '0;
            hash_acc        = '0;
        endfunction

        function void take_word(logic [31:0] w);
            logic [31:0]           z;
            logic [31:0]           t;
            logic [COUNT_BITS-1:0] full;
            if (words_per_block == 0) begin
                seen     = '0;
                hash_acc = '0;
                pending_sums.push_back(32'd0);
                return;
            end
            full = words_per_block & ~COUNT_BITS'(7);
            z = (seen == 0) ? 32'(words_per_block) * SEED_MULT : hash_acc;
            if (seen < full) begin
                z = z + ((z << 5) ^ w);
            end else if (seen == full) begin
                // byte fields overlap on purpose: ORed, not packed
                t = (32'(w[31:24]) << 23) | (32'(w[23:16]) << 16) |
                    (32'(w[15:8]) << 7) | 32'(w[7:0]);
                repeat (int'(words_per_block[2:0])) z = z + (z << 5) + t;
            end
            if ({1'b0, seen} + 1 >= {1'b0, words_per_block}) begin
                seen     = '0;
                hash_acc = '0;
                pending_sums.push_back(z);
            end else begin
                hash_acc = z;
                seen     = seen + 1'b1;
            end
        endfunction

        function void check_checksum(logic [31:0] got);
            logic [31:0] want;
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected checksum beat, expected none, actual %08h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            if (got !== want) begin
                $display("%0t: checksum mismatch, expected %08h, actual %08h",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [COUNT_BITS-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;

    block_hash_tracker board;
    int                words_sent = 0;
    int                send_pct = 17;
    int                recv_pct = 54;

    block_word_checksum u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver backpressure, updated every cycle
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // both sides are stable mid-cycle; a beat seen here is taken at the next edge
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_checksum(m_axis_tdata);
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_word(input logic [31:0] w);
        logic taken;
        if (words_sent < 300) begin
            send_pct = 17;
            recv_pct = 54;
        end else if (words_sent < 600) begin
            send_pct = 54;
            recv_pct = 17;
        end else begin
            send_pct = 0;
            recv_pct = 0;
        end
        while ($urandom_range(99) < send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        board.take_word(w);
        words_sent++;
    endtask

    // drain all checksums, then let the closing stages empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending_sums.size() != 0) @(posedge i_clk);
        repeat (WAIT_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [COUNT_BITS-1:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.set_count(v);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [COUNT_BITS-1:0] wc;
        int                    n;
        board         = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one block at the reset count
        repeat (31) send_word(random_word());

        // single-word blocks: only the tail path
        write_count(1);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h8080_8080);
        send_word(32'h0101_0101);
        // zero count: every beat closes an empty block
        write_count(0);
        repeat (3) send_word(random_word());
        // eight mixed words, then a tail repeated once
        write_count(9);
        send_word(32'h0000_0000);
        send_word(32'h8000_0000);
        send_word(32'h0000_0001);
        send_word(32'hFF00_0000);
        send_word(32'h0000_00FF);
        send_word(32'h00FF_0000);
        send_word(32'h0000_FF00);
        send_word(32'h1234_5678);
        send_word(32'hFFFF_FFFF);
        // tail only, repeated seven times
        write_count(7);
        repeat (7) send_word(random_word());
        // largest count; block abandoned by the next write
        write_count('1);
        repeat (3) send_word(random_word());

        while (words_sent < RANDOM_WORDS) begin
            case ($urandom_range(19))
                0:       wc = '0;
                1:       wc = COUNT_BITS'($urandom_range(1024, (1 << COUNT_BITS) - 1));
                2, 3, 4: wc = COUNT_BITS'($urandom_range(25, 70));
                default: wc = COUNT_BITS'($urandom_range(1, 24));
            endcase
            write_count(wc);
            if (wc == 0)
                n = $urandom_range(1, 5);
            else if (wc > 70)
                n = $urandom_range(1, 6);
            else begin
                n = $urandom_range(1, 4) * wc;
                if ($urandom_range(3) == 0) n += $urandom_range(0, wc - 1);
            end
            repeat (n) send_word(random_word());
        end

        s_axis_tvalid <= 1'b0;
        n = 0;
        while (board.pending_sums.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (WAIT_CYCLES) @(posedge i_clk);
        if (board.pending_sums.size() != 0) begin
            $display("%0t: %0d checksums never arrived, expected %08h, actual none",
                     $time, board.pending_sums.size(), board.pending_sums[0]);
            board.errors++;
        end
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
